[src/hscd_pkg.sv]
// shared types and constants of the header sync checksum deframer
`default_nettype none

package hscd_pkg;

    // payload and register widths
    localparam int BYTE_W        = 8;
    localparam int OFFSET_W      = 6;
    localparam int FRAME_LEN_W   = 7;
    localparam int SUM_START_W   = 6;
    localparam int SUM_COUNT_W   = 7;
    localparam int SUM_POS_W     = 6;
    localparam int WINDOW_W      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int MIN_FRAME     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_POSITION = 3'd5;

    // register reset values
    localparam logic [BYTE_W-1:0]      RST_SYNC_FIRST   = 8'hAA;
    localparam logic [BYTE_W-1:0]      RST_SYNC_SECOND  = 8'h55;
    localparam logic [FRAME_LEN_W-1:0] RST_FRAME_LENGTH = 7'd32;
    localparam logic [SUM_START_W-1:0] RST_SUM_START    = 6'd2;
    localparam logic [SUM_COUNT_W-1:0] RST_SUM_COUNT    = 7'd29;
    localparam logic [SUM_POS_W-1:0]   RST_SUM_POSITION = 6'd31;

    // per-cell control
    typedef struct packed {
        logic load;
        logic advance;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[src/hscd_if.sv]
// stream interfaces for received bytes and emitted frame bytes
`default_nettype none

interface hscd_rx_if import hscd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hscd_frame_if import hscd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   frame_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_end;

    modport source (output valid, output frame_byte, output byte_offset,
                    output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input byte_offset,
                    input frame_end, output ready);
endinterface

`default_nettype wire

[src/header_sync_checksum_deframer.sv]
// top level: byte buffer chain with header search, checksum check and frame emission
// steps: take a byte, shift once per search step, check the header at the front, rotate
//   the first len cells per checksum attempt (len = frame length clamped to 3..max), then
//   emit the frame byte by byte; a new byte is taken only when idle, once the search,
//   checksum attempts and emission for the last byte end; emission waits on sink stalls
// reset: buffer empty, registers at their defaults, cell contents undefined until loaded
`default_nettype none

module header_sync_checksum_deframer import hscd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    hscd_rx_if.sink              rx_stream,
    hscd_frame_if.source         frame_stream
);

    // count width holds 0..MAX_FRAME_BYTES
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // configuration registers
    logic [BYTE_W-1:0]      sync_first_reg;
    logic [BYTE_W-1:0]      sync_second_reg;
    logic [FRAME_LEN_W-1:0] frame_length_reg;
    logic [SUM_START_W-1:0] sum_start_reg;
    logic [SUM_COUNT_W-1:0] sum_count_reg;
    logic [SUM_POS_W-1:0]   sum_position_reg;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [BYTE_W-1:0] recv_reg, recv_next;

    // chain controls
    logic              load_en;
    logic              shift_all;
    logic              rotating;
    logic [LEN_W-1:0]  load_pos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] cell_q [MAX_FRAME_BYTES];

    logic rx_xact;
    logic frame_xact;
    logic synced;
    logic in_window;
    logic pos_hit;
    logic last_pos;

    logic [WINDOW_W-1:0] win_start;
    logic [WINDOW_W-1:0] win_end;
    logic [WINDOW_W-1:0] pos_w;

    // configuration writes, expected only while the stream is idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg   <= RST_SYNC_FIRST;
            sync_second_reg  <= RST_SYNC_SECOND;
            frame_length_reg <= RST_FRAME_LENGTH;
            sum_start_reg    <= RST_SUM_START;
            sum_count_reg    <= RST_SUM_COUNT;
            sum_position_reg <= RST_SUM_POSITION;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:   sync_first_reg   <= cfg_data;
                CFG_SYNC_SECOND:  sync_second_reg  <= cfg_data;
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[FRAME_LEN_W-1:0];
                CFG_SUM_START:    sum_start_reg    <= cfg_data[SUM_START_W-1:0];
                CFG_SUM_COUNT:    sum_count_reg    <= cfg_data[SUM_COUNT_W-1:0];
                CFG_SUM_POSITION: sum_position_reg <= cfg_data[SUM_POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // frame length clamped to 3..MAX_FRAME_BYTES
    always_comb
    begin
        if (frame_length_reg < FRAME_LEN_W'(MIN_FRAME))
        begin
            len = LEN_W'(MIN_FRAME);
        end
        else if (frame_length_reg > FRAME_LEN_W'(MAX_FRAME_BYTES))
        begin
            len = LEN_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            len = LEN_W'(frame_length_reg);
        end
    end

    // a full buffer is emptied before the new byte goes in
    assign load_pos = (fill_reg == LEN_W'(MAX_FRAME_BYTES)) ? '0 : fill_reg;

    // cell chain: each cell takes its right neighbor; during a checksum pass
    // the first len cells rotate so the frame comes back intact afterward
    for (genvar i = 0; i < MAX_FRAME_BYTES; i++)
    begin : g_cell
        localparam logic [LEN_W-1:0] IDX = LEN_W'(i);

        cell_ctrl_t        ctrl;
        logic [BYTE_W-1:0] neighbor;

        if (i == MAX_FRAME_BYTES - 1)
        begin : g_tail
            assign neighbor = cell_q[0];
        end
        else
        begin : g_body
            assign neighbor = (rotating && (IDX == len - LEN_W'(1))) ?
                              cell_q[0] : cell_q[i + 1];
        end

        assign ctrl.load    = load_en && (IDX == load_pos);
        assign ctrl.advance = shift_all || (rotating && (IDX < len));

        hscd_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_byte (rx_stream.rx_byte),
            .next_byte (neighbor),
            .held_byte (cell_q[i])
        );
    end

    // handshakes
    assign rx_stream.ready    = (state_reg == ST_IDLE);
    assign rx_xact            = rx_stream.valid && rx_stream.ready;
    assign frame_stream.valid = (state_reg == ST_EMIT);
    assign frame_xact         = frame_stream.valid && frame_stream.ready;

    // header sits at the front
    assign synced = (cell_q[0] == sync_first_reg) && (cell_q[1] == sync_second_reg);

    // checksum window over the byte at the front during rotation
    assign pos_w     = WINDOW_W'(pos_reg);
    assign win_start = WINDOW_W'(sum_start_reg);
    assign win_end   = WINDOW_W'(sum_start_reg) + WINDOW_W'(sum_count_reg);
    assign in_window = (pos_w >= win_start) && (pos_w < win_end);
    assign pos_hit   = (pos_w == WINDOW_W'(sum_position_reg));
    assign last_pos  = (pos_reg == len - LEN_W'(1));

    // output payload straight from the front cell
    assign frame_stream.frame_byte  = cell_q[0];
    assign frame_stream.byte_offset = OFFSET_W'(pos_reg);
    assign frame_stream.frame_end   = last_pos;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        recv_next  = recv_reg;
        load_en    = 1'b0;
        shift_all  = 1'b0;
        rotating   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_xact)
                begin
                    load_en   = 1'b1;
                    fill_next = load_pos + LEN_W'(1);
                    // a lone byte stays without a search
                    if (load_pos != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (synced)
                begin
                    if (fill_reg < len)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = '0;
                        acc_next   = '0;
                        recv_next  = '0;
                        state_next = ST_SUM;
                    end
                end
                else
                begin
                    shift_all = 1'b1;
                    if (fill_reg == LEN_W'(2))
                    begin
                        // no header anywhere: keep last byte only if it may start one
                        fill_next  = (cell_q[1] == sync_first_reg) ? LEN_W'(1) : '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fill_next = fill_reg - LEN_W'(1);
                    end
                end
            end
            ST_SUM:
            begin
                rotating = 1'b1;
                if (in_window)
                begin
                    acc_next = acc_reg + cell_q[0];
                end
                if (pos_hit)
                begin
                    recv_next = cell_q[0];
                end
                pos_next = pos_reg + LEN_W'(1);
                if (last_pos)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (acc_reg == recv_reg)
                begin
                    pos_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // bad checksum: drop one byte and search again
                    shift_all  = 1'b1;
                    fill_next  = fill_reg - LEN_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (frame_xact)
                begin
                    shift_all = 1'b1;
                    fill_next = fill_reg - LEN_W'(1);
                    pos_next  = pos_reg + LEN_W'(1);
                    if (last_pos)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
        end
    end

    // checksum datapath
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        recv_reg <= recv_next;
    end

endmodule

`default_nettype wire

[src/hscd_cell.sv]
// one byte cell of the buffer chain
`default_nettype none

module hscd_cell import hscd_pkg::*;
(
    input  wire               clk,
    input  cell_ctrl_t        ctrl,
    input  wire  [BYTE_W-1:0] load_byte,
    input  wire  [BYTE_W-1:0] next_byte,
    output logic [BYTE_W-1:0] held_byte
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // new byte wins over neighbor transfer
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_byte;
        end
        else if (ctrl.advance)
        begin
            data_next = next_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign held_byte = data_reg;

endmodule

`default_nettype wire

[verif/tb_header_sync_checksum_deframer.sv]
// self-checking testbench of the header sync checksum deframer: stream stimulus with predicted frames
`default_nettype none

module tb_header_sync_checksum_deframer import hscd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // buffer depth of the block under test
    localparam int MAX_BYTES = 64;
    // quiet cycles before a register write: a full rescan plus one emission
    localparam int SETTLE_CYCLES = 4500;
    // cycles without any transaction before the run is abandoned
    localparam int WATCHDOG_LIMIT = 40000;
    // length of the one long output hold-off
    localparam int HOLD_CYCLES = 600;

    // one emitted byte of a validated frame
    typedef struct packed {
        logic [BYTE_W-1:0]   frame_byte;
        logic [OFFSET_W-1:0] byte_offset;
        logic                frame_end;
    } frame_beat_t;

    // how a generated frame is damaged, if at all
    typedef enum int {
        FRAME_GOOD,
        FRAME_CORRUPT,
        FRAME_CUT
    } frame_kind_t;

    // output side stall behavior
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE
    } sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hscd_rx_if    rx_if ();
    hscd_frame_if frame_if ();

    header_sync_checksum_deframer #(
        .MAX_FRAME_BYTES (MAX_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_stream    (rx_if),
        .frame_stream (frame_if)
    );

    // bytes waiting to be offered on the receive stream
    logic [BYTE_W-1:0] rx_bytes_pending [$];
    // frame bytes predicted but not yet seen on the output stream
    frame_beat_t       frame_beats_due [$];

    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int error_count    = 0;

    // predictor copy of the registers
    logic [BYTE_W-1:0]      hdr_first;
    logic [BYTE_W-1:0]      hdr_second;
    logic [FRAME_LEN_W-1:0] frame_len_reg;
    logic [SUM_START_W-1:0] sum_start_reg;
    logic [SUM_COUNT_W-1:0] sum_count_reg;
    logic [SUM_POS_W-1:0]   sum_pos_reg;

    // predictor copy of the byte buffer
    logic [BYTE_W-1:0] rx_window [MAX_BYTES];
    int                window_fill = 0;

    // sender burst state
    int burst_left;
    int gap_left;

    // receiver stall state
    sink_mode_t sink_mode;
    int         mode_left;
    int         hold_left;
    logic       hold_armed = 1'b0;
    logic       hold_done;

    int idle_cycles = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // frame length as the block uses it: saturated to the legal range
    function automatic int clamp_len(input logic [FRAME_LEN_W-1:0] l);
        int n;
        n = l;
        if (n < MIN_FRAME)
            n = MIN_FRAME;
        if (n > MAX_BYTES)
            n = MAX_BYTES;
        return n;
    endfunction

    // remove n bytes from the front of the predicted buffer
    function automatic void discard_front(input int n);
        int k;
        if (n >= window_fill)
            window_fill = 0;
        else
        begin
            for (k = 0; k < window_fill - n; k++)
                rx_window[k] = rx_window[k + n];
            window_fill -= n;
        end
    endfunction

    // add one received byte to the buffer, search the header, check the sum
    // and queue the frame bytes that this byte releases
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        int                len;
        int                head;
        int                k;
        int                sum;
        int                recv;
        logic [BYTE_W-1:0] last;
        bit                busy;
        frame_beat_t       beat;
        len = clamp_len(frame_len_reg);
        // a full buffer is emptied before the new byte goes in
        if (window_fill >= MAX_BYTES)
            window_fill = 0;
        rx_window[window_fill] = b;
        window_fill++;
        busy = 1'b1;
        while (busy && window_fill >= 2)
        begin
            head = window_fill;
            k = 0;
            while (head == window_fill && k + 1 < window_fill)
            begin
                if (rx_window[k] == hdr_first && rx_window[k + 1] == hdr_second)
                    head = k;
                k++;
            end
            if (head >= window_fill)
            begin
                // no header: keep only a trailing first header byte
                last = rx_window[window_fill - 1];
                rx_window[0] = last;
                window_fill = (last == hdr_first) ? 1 : 0;
                busy = 1'b0;
            end
            else
            begin
                if (head > 0)
                    discard_front(head);
                if (window_fill < len)
                    busy = 1'b0;
                else
                begin
                    // offsets at or past the frame length add nothing
                    sum = 0;
                    for (k = 0; k < sum_count_reg; k++)
                        if (sum_start_reg + k < len)
                            sum += rx_window[sum_start_reg + k];
                    recv = (sum_pos_reg < len) ? rx_window[sum_pos_reg] : 0;
                    if (sum[BYTE_W-1:0] == recv)
                    begin
                        for (k = 0; k < len; k++)
                        begin
                            beat.frame_byte  = rx_window[k];
                            beat.byte_offset = k[OFFSET_W-1:0];
                            beat.frame_end   = (k == len - 1);
                            frame_beats_due.push_back(beat);
                        end
                        discard_front(len);
                        // at most one frame per received byte
                        busy = 1'b0;
                    end
                    else
                        discard_front(1);
                end
            end
        end
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endfunction

    // build one frame for the given layout, fix up its checksum, optionally
    // damage or shorten it, and queue it; returns the number of bytes queued
    function automatic int queue_frame(input frame_kind_t kind, input int len,
                                       input int start, input int cnt, input int pos,
                                       input logic [BYTE_W-1:0] sf,
                                       input logic [BYTE_W-1:0] ss);
        logic [BYTE_W-1:0] fr [MAX_BYTES];
        int                sum;
        int                k;
        int                adj;
        int                recv;
        int                n;
        fr[0] = sf;
        fr[1] = ss;
        for (k = 2; k < len; k++)
            fr[k] = 8'($urandom_range(0, 255));
        sum = 0;
        for (k = start; k < start + cnt && k < len; k++)
            sum += fr[k];
        if (pos >= 2 && pos < len && !(pos >= start && pos < start + cnt))
            fr[pos] = sum[BYTE_W-1:0];
        else
        begin
            // checksum byte is summed itself, fixed or out of the frame:
            // balance the sum with another summed payload byte
            adj = -1;
            for (k = 2; k < len; k++)
                if (k >= start && k < start + cnt && k != pos)
                    adj = k;
            if (adj >= 0)
            begin
                recv = (pos < len) ? fr[pos] : 0;
                fr[adj] = 8'(fr[adj] + recv - sum);
            end
        end
        n = len;
        if (kind == FRAME_CORRUPT)
        begin
            k = $urandom_range(2, len - 1);
            fr[k] = fr[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (kind == FRAME_CUT)
            n = $urandom_range(2, len - 1);
        for (k = 0; k < n; k++)
            queue_byte(fr[k]);
        return n;
    endfunction

    // mixed traffic for the current register setting: mostly well-formed
    // frames, plus damaged and cut frames, noise and stray header bytes
    function automatic void queue_traffic(input int budget);
        int n;
        int len;
        int pick;
        int run;
        int k;
        n = 0;
        len = clamp_len(frame_len_reg);
        while (n < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                n += queue_frame(FRAME_GOOD, len, sum_start_reg, sum_count_reg,
                                 sum_pos_reg, hdr_first, hdr_second);
            else if (pick == 6)
                n += queue_frame(FRAME_CORRUPT, len, sum_start_reg, sum_count_reg,
                                 sum_pos_reg, hdr_first, hdr_second);
            else if (pick == 7)
                n += queue_frame(FRAME_CUT, len, sum_start_reg, sum_count_reg,
                                 sum_pos_reg, hdr_first, hdr_second);
            else if (pick == 8)
            begin
                run = $urandom_range(1, 6);
                for (k = 0; k < run; k++)
                    queue_byte(($urandom_range(0, 2) == 0) ? hdr_first
                                                           : 8'($urandom_range(0, 255)));
                n += run;
            end
            else
            begin
                queue_byte(hdr_first);
                n++;
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_byte(hdr_second);
                    n++;
                end
            end
        end
    endfunction

    // wait until every byte is taken and every frame byte has come out,
    // then give the block time to finish any rescan that emits nothing
    task automatic wait_idle();
        while (bytes_accepted != bytes_queued)
            @(posedge clk);
        while (frame_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the enable stays high across back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SYNC_FIRST:   hdr_first     = val;
            CFG_SYNC_SECOND:  hdr_second    = val;
            CFG_FRAME_LENGTH: frame_len_reg = val[FRAME_LEN_W-1:0];
            CFG_SUM_START:    sum_start_reg = val[SUM_START_W-1:0];
            CFG_SUM_COUNT:    sum_count_reg = val[SUM_COUNT_W-1:0];
            CFG_SUM_POSITION: sum_pos_reg   = val[SUM_POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] sf,
                              input logic [CFG_DATA_W-1:0] ss,
                              input logic [CFG_DATA_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] start,
                              input logic [CFG_DATA_W-1:0] cnt,
                              input logic [CFG_DATA_W-1:0] pos);
        wait_idle();
        cfg_write(CFG_SYNC_FIRST, sf);
        cfg_write(CFG_SYNC_SECOND, ss);
        cfg_write(CFG_FRAME_LENGTH, len);
        cfg_write(CFG_SUM_START, start);
        cfg_write(CFG_SUM_COUNT, cnt);
        cfg_write(CFG_SUM_POSITION, pos);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender: bursts of random length, random gaps, some long gap-free runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!rx_if.valid || rx_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end
            else if (rx_bytes_pending.size() != 0)
            begin
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= rx_bytes_pending.pop_front();
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    // receiver: stall pattern that changes every so often, plus one long
    // hold-off that backs the block up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_if.ready <= 1'b0;
            sink_mode = SINK_OPEN;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    sink_mode = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 200);
                end
                else
                    mode_left--;
                case (sink_mode)
                    SINK_OPEN:   frame_if.ready <= 1'b1;
                    SINK_COIN:   frame_if.ready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: frame_if.ready <= ($urandom_range(0, 3) == 0);
                    default:     frame_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // predict on every accepted receive transaction
    always @(posedge clk)
    begin
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            deframe_byte(rx_if.rx_byte);
            bytes_accepted++;
        end
    end

    // compare every accepted frame transaction with the oldest prediction
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            if (frame_beats_due.size() == 0)
            begin
                $display("%0t unexpected frame byte %02h offset %0d end %0b", $time,
                         frame_if.frame_byte, frame_if.byte_offset, frame_if.frame_end);
                error_count++;
            end
            else
            begin
                want = frame_beats_due.pop_front();
                if (frame_if.frame_byte !== want.frame_byte)
                begin
                    $display("%0t frame_byte mismatch: expected %02h actual %02h", $time,
                             want.frame_byte, frame_if.frame_byte);
                    error_count++;
                end
                if (frame_if.byte_offset !== want.byte_offset)
                begin
                    $display("%0t byte_offset mismatch: expected %0d actual %0d", $time,
                             want.byte_offset, frame_if.byte_offset);
                    error_count++;
                end
                if (frame_if.frame_end !== want.frame_end)
                begin
                    $display("%0t frame_end mismatch: expected %0b actual %0b", $time,
                             want.frame_end, frame_if.frame_end);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles", $time,
                         WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SYNC_FIRST;
        cfg_data       = '0;
        hdr_first      = RST_SYNC_FIRST;
        hdr_second     = RST_SYNC_SECOND;
        frame_len_reg  = RST_FRAME_LENGTH;
        sum_start_reg  = RST_SUM_START;
        sum_count_reg  = RST_SUM_COUNT;
        sum_pos_reg    = RST_SUM_POSITION;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: lone bytes stay, bytes without a header are
        // dropped, a trailing first header byte is kept, a header is found
        // one byte in
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hAA);
        queue_byte(8'h13);
        queue_byte(8'hAA);
        queue_byte(8'hAA);
        queue_byte(8'h55);

        // frame length below the minimum saturates to three; summed range
        // and checksum byte both past the frame, so any frame passes
        set_config(8'hAA, 8'h55, 8'd2, 8'd63, 8'd64, 8'd63);
        queue_byte(8'h5A);

        // header 00 FF, checksum byte inside its own summed range:
        // one passing frame, then the same frame with a bad payload byte
        set_config(8'h00, 8'hFF, 8'd4, 8'd0, 8'd4, 8'd3);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h01);
        queue_byte(8'h77);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h02);
        queue_byte(8'h77);

        // reset values again, with the long output hold-off
        set_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_FRAME_LENGTH, RST_SUM_START,
                   RST_SUM_COUNT, RST_SUM_POSITION);
        hold_armed <= 1'b1;
        queue_traffic(70);

        // several frames buffered: fill under a long frame length, then
        // shorten it so that each further byte releases one frame
        set_config(8'h5A, 8'hC3, 8'd40, 8'd2, 8'd2, 8'd4);
        for (i = 0; i < 6; i++)
            void'(queue_frame(FRAME_GOOD, 5, 2, 2, 4, 8'h5A, 8'hC3));
        set_config(8'h5A, 8'hC3, 8'd5, 8'd2, 8'd2, 8'd4);
        for (i = 0; i < 6; i++)
            queue_byte(8'h11);

        // shortest frame, equal header bytes, one summed byte
        set_config(8'h00, 8'h00, 8'd3, 8'd0, 8'd1, 8'd2);
        queue_traffic(30);

        // length above the maximum saturates to 64, checksum on the header
        set_config(8'hFF, 8'hFF, 8'd127, 8'd1, 8'd64, 8'd0);
        queue_traffic(130);

        // short frames with a random layout
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(4, 12)), 8'($urandom_range(0, 12)),
                   8'($urandom_range(1, 12)), 8'($urandom_range(0, 12)));
        queue_traffic(50);

        // drain: everything taken, every predicted byte seen, block quiet
        wait_idle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
